// ===== src/pktl_pkg.sv =====
// ----------------------------------------------------------------------------
// pktl_pkg
// Shared types, constants and the character code map for the packed key
// table lookup.
// ----------------------------------------------------------------------------
package pktl_pkg;

    localparam int MAX_KEYS_DEF  = 64;
    localparam int KEY_CHARS_DEF = 10;

    localparam int CODE_W    = 6;
    localparam int PAYLOAD_W = 60;
    localparam int LEN_W     = 4;
    localparam int SLOT_W    = 6;
    localparam int KCNT_W    = 7;
    localparam int ENTRY_W   = PAYLOAD_W + LEN_W;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_CHAR = 1'b1;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_INVALID   = 2'd2
    } t_status;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_SCAN = 1'b1
    } t_bk_state;

    // one queued word: a table load or a finished key to look up
    typedef struct packed {
        logic                 is_load;
        logic                 bad;
        logic [SLOT_W-1:0]    idx;
        logic [PAYLOAD_W-1:0] payload;
        logic [LEN_W-1:0]     length;
    } t_job;

    // {ok, code}; ok is low for bytes outside the four classes
    function automatic logic [CODE_W:0] char_code(input logic [7:0] c);
        logic [CODE_W:0] r;
        r = '0;
        if (c inside {[8'h61:8'h7A]}) begin
            r = {1'b1, CODE_W'(c - 8'h60)};
        end else if (c inside {[8'h41:8'h5A]}) begin
            r = {1'b1, CODE_W'(c - 8'h26)};
        end else if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, CODE_W'(c + 8'h05)};
        end else if (c == 8'h5F) begin
            r = {1'b1, CODE_W'(63)};
        end
        return r;
    endfunction

endpackage

// ===== src/pktl_front.sv =====
// ----------------------------------------------------------------------------
// pktl_front
// Takes items, maps key characters to codes and packs them; queues table
// loads and finished keys.
// ----------------------------------------------------------------------------
module pktl_front import pktl_pkg::*; #(
    parameter int KEY_CHARS = KEY_CHARS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic                 i_req_type,
    input  logic [SLOT_W-1:0]    i_entry_index,
    input  logic [PAYLOAD_W-1:0] i_entry_payload,
    input  logic [LEN_W-1:0]     i_entry_length,
    input  logic [7:0]           i_key_char,
    input  logic                 i_key_last,
    output logic                 o_push,
    output t_job                 o_job
);

    localparam logic [LEN_W-1:0] KC = LEN_W'(KEY_CHARS);

    logic [PAYLOAD_W-1:0] r_acc, n_acc;
    logic [LEN_W-1:0]     r_cnt, n_cnt;
    logic                 r_bad, n_bad;

    logic [CODE_W:0]      cc;
    logic                 reject;
    logic [PAYLOAD_W-1:0] acc_c;
    logic [LEN_W-1:0]     cnt_c;
    logic                 bad_c;

    always_comb begin
        cc     = char_code(i_key_char);
        reject = !cc[CODE_W] || (r_cnt >= KC);
        acc_c  = reject ? r_acc : {r_acc[PAYLOAD_W-CODE_W-1:0], cc[CODE_W-1:0]};
        cnt_c  = reject ? r_cnt : r_cnt + LEN_W'(1);
        bad_c  = r_bad | reject;

        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_bad  = r_bad;
        o_push = 1'b0;

        o_job.is_load = 1'b0;
        o_job.bad     = bad_c || (cnt_c == '0);
        o_job.idx     = i_entry_index;
        o_job.payload = acc_c;
        o_job.length  = cnt_c;

        if (i_req_type == REQ_LOAD) begin
            o_job.is_load = 1'b1;
            o_job.bad     = 1'b0;
            o_job.payload = i_entry_payload;
            o_job.length  = i_entry_length;
            o_push        = i_take;
        end else if (i_take) begin
            if (i_key_last) begin
                o_push = 1'b1;
                n_acc  = '0;
                n_cnt  = '0;
                n_bad  = 1'b0;
            end else begin
                n_acc = acc_c;
                n_cnt = cnt_c;
                n_bad = bad_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
            r_bad <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
            r_bad <= n_bad;
        end
    end

endmodule

// ===== src/pktl_queue.sv =====
// ----------------------------------------------------------------------------
// pktl_queue
// Short word queue between the front and the table scanner.
// ----------------------------------------------------------------------------
module pktl_queue import pktl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty,
    output logic o_full
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + Q_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - Q_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== src/pktl_back.sv =====
// ----------------------------------------------------------------------------
// pktl_back
// Key table memory and scanner: writes loads, searches slots one per cycle
// for a key, and registers the result word.
// ----------------------------------------------------------------------------
module pktl_back import pktl_pkg::*; #(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [KCNT_W-1:0]    i_cfg_wdata,
    input  t_job                 i_head,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    output t_status              o_status,
    output logic [SLOT_W-1:0]    o_match_index,
    output logic [PAYLOAD_W-1:0] o_key_payload,
    output logic [LEN_W-1:0]     o_key_length
);

    localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    t_bk_state r_state, n_state;

    logic [KCNT_W-1:0]    r_key_count;
    logic [ENTRY_W-1:0]   r_table [MAX_KEYS];
    logic [ENTRY_W-1:0]   r_rd;

    logic [CNT_W-1:0]     r_addr, n_addr;
    logic [CNT_W-1:0]     r_lim, n_lim;
    logic                 r_cmp_vld, n_cmp_vld;
    logic [CNT_W-1:0]     r_cmp_idx, n_cmp_idx;
    logic [PAYLOAD_W-1:0] r_key_pl, n_key_pl;
    logic [LEN_W-1:0]     r_key_len, n_key_len;

    logic                 r_vld, n_vld;
    t_status              r_status, n_status;
    logic [SLOT_W-1:0]    r_idx, n_idx;
    logic [PAYLOAD_W-1:0] r_pl, n_pl;
    logic [LEN_W-1:0]     r_len, n_len;

    logic [CNT_W-1:0]     lim_c;
    logic                 in_range;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;
    logic                 issue;
    logic                 hit;
    logic                 miss_end;
    logic                 start_scan;

    always_comb begin
        if (32'(r_key_count) >= 32'(MAX_KEYS)) begin
            lim_c = CNT_W'(MAX_KEYS);
        end else begin
            lim_c = CNT_W'(r_key_count);
        end
    end

    assign in_range   = (32'(i_head.idx) < 32'(MAX_KEYS));
    assign wr_addr    = IDX_W'(i_head.idx);
    assign rd_addr    = r_addr[IDX_W-1:0];
    assign issue      = (r_state == BK_SCAN) && (r_addr < r_lim);
    assign hit        = r_cmp_vld && (r_rd[ENTRY_W-1:PAYLOAD_W] == r_key_len)
                        && (r_rd[PAYLOAD_W-1:0] == r_key_pl);
    assign miss_end   = r_cmp_vld && !hit && (r_cmp_idx == r_lim - CNT_W'(1));
    assign start_scan = !i_empty && !i_head.is_load && !i_head.bad && (lim_c != '0);

    always_comb begin
        case (r_state)
            BK_IDLE: n_state = start_scan ? BK_SCAN : BK_IDLE;
            BK_SCAN: n_state = (hit || miss_end) ? BK_IDLE : BK_SCAN;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        wr_en     = 1'b0;
        n_addr    = r_addr;
        n_lim     = r_lim;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_addr;
        n_key_pl  = r_key_pl;
        n_key_len = r_key_len;
        n_vld     = 1'b0;
        n_status  = ST_NOT_FOUND;
        n_idx     = '0;
        n_pl      = r_key_pl;
        n_len     = r_key_len;

        case (r_state)
            BK_IDLE: begin
                o_pop     = !i_empty;
                wr_en     = !i_empty && i_head.is_load && in_range;
                n_addr    = '0;
                n_lim     = lim_c;
                n_key_pl  = i_head.payload;
                n_key_len = i_head.length;
                n_pl      = i_head.payload;
                n_len     = i_head.length;
                if (!i_empty && !i_head.is_load) begin
                    if (i_head.bad) begin
                        n_vld    = 1'b1;
                        n_status = ST_INVALID;
                        n_pl     = '0;
                        n_len    = '0;
                    end else if (lim_c == '0) begin
                        n_vld = 1'b1;
                    end
                end
            end
            BK_SCAN: begin
                if (hit) begin
                    n_vld    = 1'b1;
                    n_status = ST_FOUND;
                    n_idx    = SLOT_W'(r_cmp_idx);
                end else if (miss_end) begin
                    n_vld = 1'b1;
                end else begin
                    n_cmp_vld = issue;
                    if (issue) begin
                        n_addr = r_addr + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= {i_head.length, i_head.payload};
        end
        r_rd <= r_table[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_key_count <= '0;
            r_cmp_vld   <= 1'b0;
            r_vld       <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_vld     <= n_vld;
            if (i_cfg_we) begin
                r_key_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_lim     <= n_lim;
        r_cmp_idx <= n_cmp_idx;
        r_key_pl  <= n_key_pl;
        r_key_len <= n_key_len;
        r_status  <= n_status;
        r_idx     <= n_idx;
        r_pl      <= n_pl;
        r_len     <= n_len;
    end

    assign o_valid       = r_vld;
    assign o_status      = r_status;
    assign o_match_index = r_idx;
    assign o_key_payload = r_pl;
    assign o_key_length  = r_len;

endmodule

// ===== src/packed_key_table_lookup.sv =====
// ----------------------------------------------------------------------------
// packed_key_table_lookup
// Streams key characters, packs them into 6-bit codes and looks the key up
// in a table of packed keys.
// ----------------------------------------------------------------------------
// An item (table load or key character) is taken on any cycle with start
// high and busy low; the front packs one character per cycle. Loads and
// finished keys pass through a two-word queue to the table scanner, which
// reads one slot per cycle from the table. A lookup scans min(key_count,
// MAX_KEYS) slots (fewer on an early match) and holds the next queued word
// until it ends; loads, invalid keys and key_count of zero scan no slot. busy
// rises while the queue holds two words. Each result appears for a single
// cycle with o_valid high; it is not held, so the receiver must take it.
module packed_key_table_lookup import pktl_pkg::*; #(
    parameter int MAX_KEYS  = MAX_KEYS_DEF,
    parameter int KEY_CHARS = KEY_CHARS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [KCNT_W-1:0]    i_cfg_wdata,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_req_type,
    input  logic [SLOT_W-1:0]    i_entry_index,
    input  logic [PAYLOAD_W-1:0] i_entry_payload,
    input  logic [LEN_W-1:0]     i_entry_length,
    input  logic [7:0]           i_key_char,
    input  logic                 i_key_last,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic [SLOT_W-1:0]    o_match_index,
    output logic [PAYLOAD_W-1:0] o_key_payload,
    output logic [LEN_W-1:0]     o_key_length
);

    logic    take;
    logic    q_push;
    logic    q_pop;
    logic    q_empty;
    logic    q_full;
    t_job    q_in;
    t_job    q_head;
    t_status bk_status;

    assign busy = q_full;
    assign take = start && !q_full;

    pktl_front #(
        .KEY_CHARS (KEY_CHARS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_req_type      (i_req_type),
        .i_entry_index   (i_entry_index),
        .i_entry_payload (i_entry_payload),
        .i_entry_length  (i_entry_length),
        .i_key_char      (i_key_char),
        .i_key_last      (i_key_last),
        .o_push          (q_push),
        .o_job           (q_in)
    );

    pktl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    pktl_back #(
        .MAX_KEYS (MAX_KEYS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_head        (q_head),
        .i_empty       (q_empty),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .o_status      (bk_status),
        .o_match_index (o_match_index),
        .o_key_payload (o_key_payload),
        .o_key_length  (o_key_length)
    );

    assign o_status = bk_status;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_INVALID) |->
        (o_key_payload == '0 && o_key_length == '0 && o_match_index == '0))
        else $error("invalid key result carries data");

    a_valid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_INVALID) |->
        (o_key_length != '0 && 32'(o_key_length) <= 32'(KEY_CHARS)))
        else $error("key length out of range");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_NOT_FOUND) |-> (o_match_index == '0))
        else $error("index set on a miss");

endmodule

// ===== tb/sv/pktl_lookup_checker.sv =====
// ----------------------------------------------------------------------------
// pktl_lookup_checker
// Watches the word and result channels of the packed key table lookup, keeps
// its own copy of the table and the key being collected, works out each
// lookup result and compares it with what the block returns, in order.
// ----------------------------------------------------------------------------
module pktl_lookup_checker import pktl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [KCNT_W-1:0]    i_cfg_wdata,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic                 i_req_type,
    input  logic [SLOT_W-1:0]    i_entry_index,
    input  logic [PAYLOAD_W-1:0] i_entry_payload,
    input  logic [LEN_W-1:0]     i_entry_length,
    input  logic [7:0]           i_key_char,
    input  logic                 i_key_last,
    input  logic                 i_valid,
    input  logic [1:0]           i_status,
    input  logic [SLOT_W-1:0]    i_match_index,
    input  logic [PAYLOAD_W-1:0] i_key_payload,
    input  logic [LEN_W-1:0]     i_key_length,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UNDERSCORE_CODE = 63;

    typedef struct packed {
        t_status              status;
        logic [SLOT_W-1:0]    index;
        logic [PAYLOAD_W-1:0] payload;
        logic [LEN_W-1:0]     length;
    } t_lookup;

    logic [PAYLOAD_W-1:0] slot_payload [MAX_KEYS_DEF];
    logic [LEN_W-1:0]     slot_length  [MAX_KEYS_DEF];
    logic [KCNT_W-1:0]    keys_searched;
    logic [PAYLOAD_W-1:0] packed_key;
    logic [LEN_W-1:0]     key_chars;
    logic                 key_bad;
    t_lookup              expected_lookups [$];
    int                   lookups_seen;

    function automatic int code_of(input logic [7:0] c);
        if (c >= "a" && c <= "z") return c - "a" + 1;
        if (c >= "A" && c <= "Z") return c - "A" + 27;
        if (c >= "0" && c <= "9") return c - "0" + 53;
        if (c == "_") return UNDERSCORE_CODE;
        return -1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] pktl_lookup_checker: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic track_word();
        int      code;
        int      limit;
        t_lookup res;
        if (i_req_type == REQ_LOAD) begin
            slot_payload[i_entry_index] = i_entry_payload;
            slot_length[i_entry_index]  = i_entry_length;
            return;
        end
        code = code_of(i_key_char);
        if (code < 0 || key_chars >= KEY_CHARS_DEF) begin
            key_bad = 1'b1;
        end else begin
            packed_key = {packed_key[PAYLOAD_W-CODE_W-1:0], CODE_W'(code)};
            key_chars  = key_chars + 1'b1;
        end
        if (!i_key_last) return;
        res = '0;
        if (key_bad || key_chars == 0) begin
            res.status = ST_INVALID;
        end else begin
            res.status  = ST_NOT_FOUND;
            res.payload = packed_key;
            res.length  = key_chars;
            limit = (keys_searched < MAX_KEYS_DEF) ? keys_searched : MAX_KEYS_DEF;
            for (int s = 0; s < limit && res.status == ST_NOT_FOUND; s++) begin
                if (slot_length[s] == key_chars && slot_payload[s] == packed_key) begin
                    res.status = ST_FOUND;
                    res.index  = SLOT_W'(s);
                end
            end
        end
        expected_lookups.push_back(res);
        packed_key = '0;
        key_chars  = '0;
        key_bad    = 1'b0;
    endtask

    task automatic compare_lookup();
        t_lookup got;
        t_lookup want;
        got.status  = t_status'(i_status);
        got.index   = i_match_index;
        got.payload = i_key_payload;
        got.length  = i_key_length;
        lookups_seen++;
        if (expected_lookups.size() == 0) begin
            report_mismatch($sformatf("result %0d with no lookup pending: status %0d",
                                      lookups_seen, i_status));
        end else begin
            want = expected_lookups.pop_front();
            if (got !== want) begin
                report_mismatch($sformatf(
                    "result %0d: got %0d/%0d/%h/%0d, want %0d/%0d/%h/%0d (st/idx/key/len)",
                    lookups_seen, got.status, got.index, got.payload, got.length,
                    want.status, want.index, want.payload, want.length));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            keys_searched = '0;
            packed_key    = '0;
            key_chars     = '0;
            key_bad       = 1'b0;
            o_fail_count  = 0;
            lookups_seen  = 0;
            expected_lookups.delete();
        end else begin
            if (i_cfg_we) keys_searched = i_cfg_wdata;
            if (i_valid) compare_lookup();
            if (i_start && !i_busy) track_word();
        end
        o_pending = expected_lookups.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives table loads and key characters into the packed key table lookup
// with random gaps, walks key_count through its extremes between quiet
// phases, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top import pktl_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 160;
    localparam int PHASE_WORDS  = 72;
    // "azAZ09____"
    localparam logic [PAYLOAD_W-1:0] EDGE_NAME = {6'd1, 6'd26, 6'd27, 6'd52, 6'd53,
                                                  6'd62, 6'd63, 6'd63, 6'd63, 6'd63};

    typedef logic [7:0] t_key_bytes [$];

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [KCNT_W-1:0]    i_cfg_wdata;
    logic                 start;
    logic                 busy;
    logic                 i_req_type;
    logic [SLOT_W-1:0]    i_entry_index;
    logic [PAYLOAD_W-1:0] i_entry_payload;
    logic [LEN_W-1:0]     i_entry_length;
    logic [7:0]           i_key_char;
    logic                 i_key_last;
    logic                 o_valid;
    logic [1:0]           o_status;
    logic [SLOT_W-1:0]    o_match_index;
    logic [PAYLOAD_W-1:0] o_key_payload;
    logic [LEN_W-1:0]     o_key_length;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    int words_sent   = 0;
    int max_gap      = 8;

    logic [PAYLOAD_W-1:0] stim_payload [MAX_KEYS_DEF];
    logic [LEN_W-1:0]     stim_length  [MAX_KEYS_DEF];
    bit                   stim_named   [MAX_KEYS_DEF];

    always #4 i_clk = ~i_clk;

    packed_key_table_lookup dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_entry_index   (i_entry_index),
        .i_entry_payload (i_entry_payload),
        .i_entry_length  (i_entry_length),
        .i_key_char      (i_key_char),
        .i_key_last      (i_key_last),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_match_index   (o_match_index),
        .o_key_payload   (o_key_payload),
        .o_key_length    (o_key_length)
    );

    pktl_lookup_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_start         (start),
        .i_busy          (busy),
        .i_req_type      (i_req_type),
        .i_entry_index   (i_entry_index),
        .i_entry_payload (i_entry_payload),
        .i_entry_length  (i_entry_length),
        .i_key_char      (i_key_char),
        .i_key_last      (i_key_last),
        .i_valid         (o_valid),
        .i_status        (o_status),
        .i_match_index   (o_match_index),
        .i_key_payload   (o_key_payload),
        .i_key_length    (o_key_length),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    function automatic logic [7:0] char_of(input logic [CODE_W-1:0] code);
        if (code <= 6'd26) return 8'(code) - 8'd1 + "a";
        if (code <= 6'd52) return 8'(code) - 8'd27 + "A";
        if (code <= 6'd62) return 8'(code) - 8'd53 + "0";
        return "_";
    endfunction

    function automatic logic [PAYLOAD_W-1:0] random_name(input int len);
        logic [PAYLOAD_W-1:0] p;
        p = '0;
        for (int k = 0; k < len; k++) begin
            p = {p[PAYLOAD_W-CODE_W-1:0], CODE_W'($urandom_range(1, 63))};
        end
        return p;
    endfunction

    // start stays high across back-to-back words
    task automatic send_word(input logic req, input logic [SLOT_W-1:0] idx,
                             input logic [PAYLOAD_W-1:0] pay, input logic [LEN_W-1:0] len,
                             input logic [7:0] ch, input logic last);
        int gap;
        gap = $urandom_range(0, max_gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start           <= 1'b1;
        i_req_type      <= req;
        i_entry_index   <= idx;
        i_entry_payload <= pay;
        i_entry_length  <= len;
        i_key_char      <= ch;
        i_key_last      <= last;
        do @(posedge i_clk); while (busy);
        words_sent++;
    endtask

    task automatic send_char(input logic [7:0] ch, input logic last);
        send_word(REQ_CHAR, SLOT_W'($urandom), PAYLOAD_W'({$urandom, $urandom}),
                  LEN_W'($urandom), ch, last);
    endtask

    task automatic set_slot(input logic [SLOT_W-1:0] slot, input logic [PAYLOAD_W-1:0] p,
                            input logic [LEN_W-1:0] len, input bit named);
        send_word(REQ_LOAD, slot, p, len, 8'($urandom), 1'($urandom));
        stim_payload[slot] = p;
        stim_length[slot]  = len;
        stim_named[slot]   = named;
    endtask

    task automatic load_random(input logic [SLOT_W-1:0] slot);
        int kind;
        int src;
        int len;
        kind = $urandom_range(0, 99);
        src  = $urandom_range(0, MAX_KEYS_DEF - 1);
        if (kind >= 55 && kind < 75 && stim_named[src]) begin
            set_slot(slot, stim_payload[src], stim_length[src], 1'b1);
        end else if (kind >= 75 && kind < 90) begin
            set_slot(slot, PAYLOAD_W'({$urandom, $urandom}), LEN_W'($urandom), 1'b0);
        end else if (kind >= 90) begin
            len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(KEY_CHARS_DEF + 1, 15);
            set_slot(slot, random_name(KEY_CHARS_DEF), LEN_W'(len), 1'b0);
        end else begin
            len = $urandom_range(1, KEY_CHARS_DEF);
            set_slot(slot, random_name(len), LEN_W'(len), 1'b1);
        end
    endtask

    // mid_load: position before which a table load is slipped into the key
    task automatic send_name(input logic [PAYLOAD_W-1:0] p, input int len, input int mid_load);
        for (int k = len - 1; k >= 0; k--) begin
            if (k == mid_load) load_random(SLOT_W'($urandom_range(4, 61)));
            send_char(char_of(p[CODE_W*k +: CODE_W]), k == 0);
        end
    endtask

    task automatic send_bytes(input t_key_bytes q);
        foreach (q[k]) send_char(q[k], k == q.size() - 1);
    endtask

    task automatic settle();
        @(negedge i_clk) start <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_key_count(input logic [KCNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    task automatic random_action();
        int                   pick;
        int                   n;
        int                   slot;
        int                   bad_at;
        logic [PAYLOAD_W-1:0] p;
        t_key_bytes           q;
        pick    = $urandom_range(0, 99);
        slot    = $urandom_range(0, MAX_KEYS_DEF - 1);
        max_gap = ($urandom_range(0, 5) == 0) ? 0 : 8;
        if (pick < 60) begin
            if (pick < 45 && stim_named[slot]) begin
                n = stim_length[slot];
                p = stim_payload[slot];
            end else begin
                n = $urandom_range(1, KEY_CHARS_DEF);
                p = random_name(n);
            end
            send_name(p, n, (n > 1 && $urandom_range(0, 6) == 0) ? $urandom_range(0, n - 2) : -1);
        end else if (pick < 70) begin
            n = $urandom_range(KEY_CHARS_DEF + 1, 14);
            repeat (n) q.push_back(char_of(CODE_W'($urandom_range(1, 63))));
            send_bytes(q);
        end else if (pick < 82) begin
            n      = $urandom_range(1, 12);
            bad_at = $urandom_range(0, n - 1);
            for (int k = 0; k < n; k++) begin
                if (k == bad_at) begin
                    q.push_back(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
                end else if ($urandom_range(0, 3) == 0) begin
                    q.push_back(8'($urandom));
                end else begin
                    q.push_back(char_of(CODE_W'($urandom_range(1, 63))));
                end
            end
            send_bytes(q);
        end else begin
            load_random(SLOT_W'(slot));
        end
    endtask

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        int         plan [8];
        int         phase_start;
        t_key_bytes overlong;
        plan            = '{64, 127, 1, 65, 0, 0, 32, 64};
        plan[5]         = $urandom_range(0, 127);
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        start           = 1'b0;
        i_req_type      = REQ_LOAD;
        i_entry_index   = '0;
        i_entry_payload = '0;
        i_entry_length  = '0;
        i_key_char      = '0;
        i_key_last      = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // key_count is zero out of reset: no slot is searched
        send_name(PAYLOAD_W'(1), 1, -1);
        send_char(8'h00, 1'b1);
        send_char("x", 1'b0);
        send_char(8'hFF, 1'b1);

        for (int s = 0; s < MAX_KEYS_DEF; s++) load_random(SLOT_W'(s));
        set_slot(0, '0, '0, 1'b0);
        set_slot(1, EDGE_NAME, LEN_W'(KEY_CHARS_DEF), 1'b1);
        set_slot(3, EDGE_NAME, LEN_W'(KEY_CHARS_DEF), 1'b1);
        set_slot(62, '1, LEN_W'(KEY_CHARS_DEF), 1'b1);
        set_slot(63, '1, '1, 1'b0);

        settle();
        write_key_count(KCNT_W'(MAX_KEYS_DEF));
        send_name(EDGE_NAME, KEY_CHARS_DEF, 5);
        repeat (KEY_CHARS_DEF + 1) overlong.push_back("_");
        send_bytes(overlong);

        foreach (plan[ph]) begin
            settle();
            write_key_count(KCNT_W'(plan[ph]));
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) random_action();
        end

        settle();
        if (fail_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
